### rtl/vrt_pkg.sv
// Shared widths, register indexes and operation codes of the voxel ray traversal block.
// Used by the block, its checker and the testbench; depends on nothing else.
`timescale 1ns / 1ps

package vrt_pkg;

    localparam int ID_W    = 8;
    localparam int COORD_W = 12;
    localparam int ORG_W   = 24;
    localparam int DIR_W   = 16;
    localparam int REACH_W = 16;
    localparam int FRAC_W  = 12;
    localparam int CFG_W   = 12;

    localparam int S_DATA_W = 184;
    localparam int M_DATA_W = 72;

    localparam logic [1:0] CFG_AIR_ID   = 2'd0;
    localparam logic [1:0] CFG_WATER_ID = 2'd1;
    localparam logic [1:0] CFG_X_OFFSET = 2'd2;
    localparam logic [1:0] CFG_Z_OFFSET = 2'd3;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_RAY   = 1'b1;

endpackage

### rtl/voxel_ray_traversal.sv
// Voxel ray traversal: a grid of cell ids in one synchronous memory and a stepping ray walker.
// Depends on rtl/vrt_pkg.sv.
//
//  channel | ports                      | payload
//  --------+----------------------------+------------------------------------------
//  input   | s_tvalid s_tready s_tdata  | write or ray item, s_tuser = operation
//  result  | m_tvalid m_tready m_tdata  | hit and before cells, m_tuser = hit
//  config  | cfg_we cfg_index cfg_wdata | air_id, water_id, x_offset, z_offset
//
// A write item is taken and written in the idle state. A ray item is taken in the idle
// state, then passes the set-up states, the bit-serial square root, and per grid step the
// product, axis choice and memory read, and solid test states; the walk is skipped at zero
// length or reach and ends at the step limit. A last state loads the output register, where
// it waits while an earlier result is held. After reset the memory is cleared one cell a
// cycle, while s_tready stays low. s_tready is high only in the idle state.
`timescale 1ns / 1ps

module voxel_ray_traversal #(
    parameter int WORLD_SIDE   = 32,
    parameter int WORLD_HEIGHT = 32,
    parameter int MAX_STEPS    = 1024
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // cell_x, cell_y, cell_z, cell_value, origin_x, origin_y, origin_z,
    // dir_x, dir_y, dir_z, reach, then zero fill
    input  logic [vrt_pkg::S_DATA_W-1:0]  s_tdata,
    // operation
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // hit_x, hit_y, hit_z, before_x, before_y, before_z
    output logic [vrt_pkg::M_DATA_W-1:0]  m_tdata,
    // hit
    output logic                          m_tuser,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [vrt_pkg::CFG_W-1:0]     cfg_wdata
);

    localparam int CELLS = WORLD_SIDE * WORLD_HEIGHT * WORLD_SIDE;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(MAX_STEPS + 2049) + 1;
    localparam int NW    = 13 + $clog2(MAX_STEPS + 1);
    localparam int PW    = NW + vrt_pkg::DIR_W;
    localparam int GW    = (PW > 36) ? PW : 36;
    localparam int SW    = $clog2(MAX_STEPS + 1);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_SQ   = 4'd1;
    localparam logic [3:0] ST_SUM  = 4'd2;
    localparam logic [3:0] ST_SQRT = 4'd3;
    localparam logic [3:0] ST_MUL  = 4'd4;
    localparam logic [3:0] ST_SEL  = 4'd5;
    localparam logic [3:0] ST_CHK  = 4'd6;
    localparam logic [3:0] ST_OUT  = 4'd7;

    function automatic logic [AW:0] cell_addr(input logic signed [CW-1:0] x,
                                              input logic signed [CW-1:0] y,
                                              input logic signed [CW-1:0] z,
                                              input logic signed [11:0] xo,
                                              input logic signed [11:0] zo);
        logic signed [CW:0] gx;
        logic signed [CW:0] gz;
        logic               ok;
        logic [31:0]        t;
        gx = {x[CW-1], x} + {{(CW-11){xo[11]}}, xo};
        gz = {z[CW-1], z} + {{(CW-11){zo[11]}}, zo};
        ok = !gx[CW] && (gx < WORLD_SIDE) && !y[CW-1] && (y < WORLD_HEIGHT) &&
             !gz[CW] && (gz < WORLD_SIDE);
        t  = (32'(gx) * 32'(WORLD_HEIGHT) + 32'(y)) * 32'(WORLD_SIDE) + 32'(gz);
        return {ok, t[AW-1:0]};
    endfunction

    logic [3:0]          state_reg;
    logic                clr_reg;
    logic [AW-1:0]       clr_cnt_reg;
    logic [7:0]          air_reg;
    logic [7:0]          water_reg;
    logic signed [11:0]  xoff_reg;
    logic signed [11:0]  zoff_reg;

    logic signed [CW-1:0] cell_reg [3];
    logic signed [CW-1:0] prev_reg [3];
    logic [NW-1:0]        num_reg  [3];
    logic [15:0]          inv_reg  [3];
    logic                 neg_reg  [3];
    logic [31:0]          sq_reg   [3];
    logic [31:0]          rinv_reg [3];
    logic [PW-1:0]        pl_reg   [3];
    logic [PW-1:0]        p01_reg, p10_reg, p02_reg, p20_reg, p12_reg, p21_reg;
    logic [15:0]          reach_reg;
    logic [15:0]          len_reg;
    logic [31:0]          sqv_reg, sqr_reg, sqb_reg;
    logic [3:0]           sqc_reg;
    logic [SW-1:0]        step_reg;
    logic                 go_reg;
    logic                 inb_reg;
    logic                 hit_reg;

    logic                 m_tvalid_reg;
    logic                 m_tuser_reg;
    logic [vrt_pkg::M_DATA_W-1:0] m_tdata_reg;

    logic [7:0]           mem [CELLS];
    logic [7:0]           rd_data_reg;

    logic                 accept;
    logic                 out_load;
    logic [AW:0]          wr_addr;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [7:0]           mem_wdata;

    logic                 tl01, tl02, tl12;
    logic [1:0]           axis;
    logic signed [CW-1:0] cell_new [3];
    logic [AW:0]          rd_addr;
    logic [31:0]          sq_t;
    logic [31:0]          sqv_next, sqr_next;
    logic [GW-1:0]        go_lhs, go_rhs;
    logic                 solid;

    assign s_tready = (state_reg == ST_IDLE) && !clr_reg;
    assign accept   = s_tvalid && s_tready;
    assign out_load = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        wr_addr = cell_addr({{(CW-12){s_tdata[11]}}, s_tdata[11:0]},
                            {{(CW-12){s_tdata[23]}}, s_tdata[23:12]},
                            {{(CW-12){s_tdata[35]}}, s_tdata[35:24]},
                            xoff_reg, zoff_reg);
        if (clr_reg) begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = 8'd0;
        end else begin
            mem_we    = accept && (s_tuser == vrt_pkg::OP_WRITE) && wr_addr[AW];
            mem_waddr = wr_addr[AW-1:0];
            mem_wdata = s_tdata[43:36];
        end
    end

    always_comb begin
        tl01 = (inv_reg[0] != 16'd0) && ((inv_reg[1] == 16'd0) || (p01_reg < p10_reg));
        tl02 = (inv_reg[0] != 16'd0) && ((inv_reg[2] == 16'd0) || (p02_reg < p20_reg));
        tl12 = (inv_reg[1] != 16'd0) && ((inv_reg[2] == 16'd0) || (p12_reg < p21_reg));
        if (tl01 && tl02) begin
            axis = 2'd0;
        end else if (tl12) begin
            axis = 2'd1;
        end else begin
            axis = 2'd2;
        end
        for (int a = 0; a < 3; a++) begin
            if (axis == 2'(a)) begin
                cell_new[a] = neg_reg[a] ? cell_reg[a] - CW'(1) : cell_reg[a] + CW'(1);
            end else begin
                cell_new[a] = cell_reg[a];
            end
        end
        rd_addr = cell_addr(cell_new[0], cell_new[1], cell_new[2], xoff_reg, zoff_reg);
        go_lhs  = GW'(pl_reg[axis]);
        go_rhs  = GW'({rinv_reg[axis], 4'd0});
        sq_t    = sqr_reg + sqb_reg;
        if (sqv_reg >= sq_t) begin
            sqv_next = sqv_reg - sq_t;
            sqr_next = (sqr_reg >> 1) + sqb_reg;
        end else begin
            sqv_next = sqv_reg;
            sqr_next = sqr_reg >> 1;
        end
        solid = inb_reg && (rd_data_reg != air_reg) && (rd_data_reg != water_reg);
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[rd_addr[AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            clr_reg      <= 1'b1;
            clr_cnt_reg  <= '0;
            air_reg      <= 8'd0;
            water_reg    <= 8'd1;
            xoff_reg     <= '0;
            zoff_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    vrt_pkg::CFG_AIR_ID:   air_reg   <= cfg_wdata[7:0];
                    vrt_pkg::CFG_WATER_ID: water_reg <= cfg_wdata[7:0];
                    vrt_pkg::CFG_X_OFFSET: xoff_reg  <= cfg_wdata;
                    vrt_pkg::CFG_Z_OFFSET: zoff_reg  <= cfg_wdata;
                    default: ;
                endcase
            end
            if (clr_reg) begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(CELLS - 1)) begin
                    clr_reg <= 1'b0;
                end
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept && (s_tuser == vrt_pkg::OP_RAY)) begin
                        for (int a = 0; a < 3; a++) begin
                            logic [23:0] o;
                            logic signed [15:0] d;
                            o = s_tdata[44 + 24*a +: 24];
                            d = s_tdata[116 + 16*a +: 16];
                            cell_reg[a] <= {{(CW-12){o[23]}}, o[23:12]};
                            neg_reg[a]  <= d[15];
                            inv_reg[a]  <= d[15] ? 16'(-d) : 16'(d);
                            if (!d[15] && (d != 16'sd0)) begin
                                num_reg[a] <= NW'(13'd4096 - {1'b0, o[11:0]});
                            end else begin
                                num_reg[a] <= NW'(o[11:0]);
                            end
                        end
                        reach_reg <= s_tdata[179:164];
                        step_reg  <= '0;
                        hit_reg   <= 1'b0;
                        state_reg <= ST_SQ;
                    end
                end
                ST_SQ: begin
                    for (int a = 0; a < 3; a++) begin
                        sq_reg[a]   <= 32'(inv_reg[a]) * 32'(inv_reg[a]);
                        rinv_reg[a] <= 32'(reach_reg) * 32'(inv_reg[a]);
                    end
                    state_reg <= ST_SUM;
                end
                ST_SUM: begin
                    sqv_reg   <= sq_reg[0] + sq_reg[1] + sq_reg[2];
                    sqr_reg   <= 32'd0;
                    sqb_reg   <= 32'h4000_0000;
                    sqc_reg   <= 4'd0;
                    state_reg <= ST_SQRT;
                end
                ST_SQRT: begin
                    sqv_reg <= sqv_next;
                    sqr_reg <= sqr_next;
                    sqb_reg <= sqb_reg >> 2;
                    sqc_reg <= sqc_reg + 4'd1;
                    if (sqc_reg == 4'd15) begin
                        len_reg <= sqr_next[15:0];
                        if ((sqr_next == 32'd0) || (reach_reg == 16'd0)) begin
                            state_reg <= ST_OUT;
                        end else begin
                            state_reg <= ST_MUL;
                        end
                    end
                end
                ST_MUL: begin
                    if (step_reg >= SW'(MAX_STEPS)) begin
                        state_reg <= ST_OUT;
                    end else begin
                        p01_reg <= PW'(num_reg[0]) * PW'(inv_reg[1]);
                        p10_reg <= PW'(num_reg[1]) * PW'(inv_reg[0]);
                        p02_reg <= PW'(num_reg[0]) * PW'(inv_reg[2]);
                        p20_reg <= PW'(num_reg[2]) * PW'(inv_reg[0]);
                        p12_reg <= PW'(num_reg[1]) * PW'(inv_reg[2]);
                        p21_reg <= PW'(num_reg[2]) * PW'(inv_reg[1]);
                        for (int a = 0; a < 3; a++) begin
                            pl_reg[a] <= PW'(num_reg[a]) * PW'(len_reg);
                        end
                        state_reg <= ST_SEL;
                    end
                end
                ST_SEL: begin
                    for (int a = 0; a < 3; a++) begin
                        prev_reg[a] <= cell_reg[a];
                        cell_reg[a] <= cell_new[a];
                    end
                    num_reg[axis] <= num_reg[axis] + NW'(4096);
                    go_reg    <= go_lhs < go_rhs;
                    inb_reg   <= rd_addr[AW];
                    step_reg  <= step_reg + SW'(1);
                    state_reg <= ST_CHK;
                end
                ST_CHK: begin
                    if (solid) begin
                        hit_reg   <= 1'b1;
                        state_reg <= ST_OUT;
                    end else if (!go_reg) begin
                        state_reg <= ST_OUT;
                    end else begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_OUT: begin
                    if (out_load) begin
                        m_tuser_reg  <= hit_reg;
                        if (hit_reg) begin
                            m_tdata_reg <= {prev_reg[2][11:0], prev_reg[1][11:0],
                                            prev_reg[0][11:0], cell_reg[2][11:0],
                                            cell_reg[1][11:0], cell_reg[0][11:0]};
                        end else begin
                            m_tdata_reg <= '0;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

### sim/vrt_checker.sv
// Checker for the voxel ray traversal block: watches the input, result and register ports,
// keeps its own copy of the grid and the registers, and predicts and compares every ray result.
// Depends on rtl/vrt_pkg.sv.
`timescale 1ns / 1ps

module vrt_checker #(
    parameter int WORLD_SIDE   = 32,
    parameter int WORLD_HEIGHT = 32,
    parameter int MAX_STEPS    = 1024
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    input  logic                         s_tready,
    input  logic [vrt_pkg::S_DATA_W-1:0] s_tdata,
    input  logic                         s_tuser,
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic [vrt_pkg::M_DATA_W-1:0] m_tdata,
    input  logic                         m_tuser,
    input  logic                         cfg_we,
    input  logic [1:0]                   cfg_index,
    input  logic [vrt_pkg::CFG_W-1:0]    cfg_wdata,
    output int                           fail_count,
    output int                           pending,
    output int                           hit_count
);

    localparam int CELLS = WORLD_SIDE * WORLD_HEIGHT * WORLD_SIDE;

    typedef struct packed {
        logic                         hit;
        logic [vrt_pkg::M_DATA_W-1:0] cells;
    } trace_t;

    logic [vrt_pkg::ID_W-1:0] grid [CELLS];
    logic [vrt_pkg::ID_W-1:0] air_id, water_id;
    longint          x_off, z_off;
    trace_t          trace_queue [$];

    function automatic bit grid_addr(longint x, longint y, longint z, output int idx);
        longint gx, gz;
        gx = x + x_off;
        gz = z + z_off;
        idx = 0;
        if (gx < 0 || gx >= WORLD_SIDE || y < 0 || y >= WORLD_HEIGHT ||
            gz < 0 || gz >= WORLD_SIDE) return 0;
        idx = int'((gx * WORLD_HEIGHT + y) * WORLD_SIDE + gz);
        return 1;
    endfunction

    function automatic bit solid_at(longint x, longint y, longint z);
        int idx;
        if (!grid_addr(x, y, z, idx)) return 0;
        return grid[idx] != air_id && grid[idx] != water_id;
    endfunction

    function automatic longint int_sqrt(longint v);
        longint r, b;
        r = 0;
        b = 64'sd1 <<< 62;
        while (b > v) b = b >>> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >>> 1) + b;
            end else begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        return r;
    endfunction

    function automatic bit sooner(longint na, longint ma, longint nb, longint mb);
        if (ma == 0) return 0;
        if (mb == 0) return 1;
        return na * mb < nb * ma;
    endfunction

    function automatic trace_t trace_ray(logic [vrt_pkg::S_DATA_W-1:0] d);
        trace_t r;
        longint org[3], cur[3], face[3], mag[3], num[3], prev[3];
        int     sg[3];
        longint l2, len, reach, dv;
        bit     go;
        int     ax, steps;
        r = '0;
        l2 = 0;
        reach = longint'(d[179:164]);
        for (int a = 0; a < 3; a++) begin
            org[a] = longint'($signed(d[44 + 24*a +: 24]));
            dv = longint'($signed(d[116 + 16*a +: 16]));
            sg[a] = (dv > 0) ? 1 : (dv < 0) ? -1 : 0;
            mag[a] = (dv < 0) ? -dv : dv;
            l2 += mag[a] * mag[a];
            cur[a] = org[a] >>> 12;
            face[a] = cur[a] + ((sg[a] > 0) ? 1 : 0);
        end
        if (l2 == 0) return r;
        len = int_sqrt(l2);
        go = reach > 0;
        steps = 0;
        while (go) begin
            if (steps >= MAX_STEPS) return r;
            for (int a = 0; a < 3; a++) begin
                prev[a] = cur[a];
                num[a] = (sg[a] > 0) ? face[a] * 4096 - org[a] : org[a] - face[a] * 4096;
            end
            if (sooner(num[0], mag[0], num[1], mag[1]) &&
                sooner(num[0], mag[0], num[2], mag[2])) ax = 0;
            else if (sooner(num[1], mag[1], num[2], mag[2])) ax = 1;
            else ax = 2;
            cur[ax] += sg[ax];
            face[ax] += sg[ax];
            go = num[ax] * len < reach * mag[ax] * 16;
            steps++;
            if (solid_at(cur[0], cur[1], cur[2])) begin
                r.hit = 1'b1;
                for (int a = 0; a < 3; a++) begin
                    r.cells[12*a +: 12] = cur[a][11:0];
                    r.cells[36 + 12*a +: 12] = prev[a][11:0];
                end
                return r;
            end
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        int     idx;
        trace_t want;
        if (!aresetn) begin
            for (int i = 0; i < CELLS; i++) grid[i] = '0;
            air_id     = 8'd0;
            water_id   = 8'd1;
            x_off      = 0;
            z_off      = 0;
            fail_count = 0;
            hit_count  = 0;
            trace_queue.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    vrt_pkg::CFG_AIR_ID: begin
                        air_id = cfg_wdata[7:0];
                    end
                    vrt_pkg::CFG_WATER_ID: begin
                        water_id = cfg_wdata[7:0];
                    end
                    vrt_pkg::CFG_X_OFFSET: begin
                        x_off = longint'($signed(cfg_wdata));
                    end
                    vrt_pkg::CFG_Z_OFFSET: begin
                        z_off = longint'($signed(cfg_wdata));
                    end
                    default: begin
                    end
                endcase
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == vrt_pkg::OP_WRITE) begin
                    if (grid_addr(longint'($signed(s_tdata[11:0])),
                                  longint'($signed(s_tdata[23:12])),
                                  longint'($signed(s_tdata[35:24])), idx))
                        grid[idx] = s_tdata[43:36];
                end else begin
                    trace_queue = {trace_queue, trace_ray(s_tdata)};
                end
            end
            if (m_tvalid && m_tready) begin
                if (trace_queue.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("Unexpected result item: hit %0b cells %h", m_tuser, m_tdata);
                end else begin
                    want = trace_queue.pop_front();
                    if (want.hit) hit_count++;
                    if (want.hit !== m_tuser || want.cells !== m_tdata) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("Mismatch: expected hit %0b cells %h, got hit %0b cells %h",
                                     want.hit, want.cells, m_tuser, m_tdata);
                    end
                end
            end
        end
        pending = trace_queue.size();
    end

endmodule

### sim/tb.sv
// Top of the voxel ray traversal testbench: clock, reset, register phases, write and ray
// stimulus with random idling, and the verdict. Depends on rtl/vrt_pkg.sv, the block and
// sim/vrt_checker.sv.
`timescale 1ns / 1ps

module tb;

    localparam int  ITEMS_PER_PHASE = 110;
    localparam longint CYCLE_LIMIT  = 10000000;

    logic                           aclk = 1'b0;
    logic                           aresetn;
    logic                           s_tvalid, s_tready, s_tuser;
    logic [vrt_pkg::S_DATA_W-1:0]   s_tdata;
    logic                           m_tvalid, m_tready, m_tuser;
    logic [vrt_pkg::M_DATA_W-1:0]   m_tdata;
    logic                           cfg_we;
    logic [1:0]                     cfg_index;
    logic [vrt_pkg::CFG_W-1:0]      cfg_wdata;
    int                             fail_count, pending, hit_count;

    bit                    calm = 1'b0;
    bit                    hold_req = 1'b0;
    bit                    hold_seen = 1'b0;
    int                    hold_cycles = 0;
    int                    items_sent = 0, rays_sent = 0;
    longint                cycles = 0;
    int                    cur_x_off = 0, cur_z_off = 0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    voxel_ray_traversal u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    vrt_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .fail_count(fail_count), .pending(pending), .hit_count(hit_count)
    );

    initial begin
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("Run exceeded %0d cycles with %0d results outstanding.",
                         CYCLE_LIMIT, pending);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        m_tready <= 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_seen) begin
                hold_seen = 1'b1;
                hold_cycles = 400;
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= calm || ($urandom_range(99) >= 11);
            end
        end
    end

    function automatic logic [vrt_pkg::S_DATA_W-1:0] write_data(int x, int y, int z, int v);
        logic [vrt_pkg::S_DATA_W-1:0] d;
        d = '0;
        d[11:0]  = x[11:0];
        d[23:12] = y[11:0];
        d[35:24] = z[11:0];
        d[43:36] = v[7:0];
        return d;
    endfunction

    function automatic logic [vrt_pkg::S_DATA_W-1:0] ray_data(int ox, int oy, int oz,
                                                              int dx, int dy, int dz,
                                                              int reach);
        logic [vrt_pkg::S_DATA_W-1:0] d;
        d = '0;
        d[67:44]   = ox[23:0];
        d[91:68]   = oy[23:0];
        d[115:92]  = oz[23:0];
        d[131:116] = dx[15:0];
        d[147:132] = dy[15:0];
        d[163:148] = dz[15:0];
        d[179:164] = reach[15:0];
        return d;
    endfunction

    task automatic send_item(logic op, logic [vrt_pkg::S_DATA_W-1:0] d);
        while (!calm && $urandom_range(99) < 11) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= d;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
        if (op == vrt_pkg::OP_RAY) rays_sent++;
        @(negedge aclk);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        repeat (16) @(negedge aclk);
    endtask

    task automatic set_regs(int air, int water, int xo, int zo);
        cfg_we <= 1'b1;
        cfg_index <= vrt_pkg::CFG_AIR_ID;   cfg_wdata <= air[11:0];   @(negedge aclk);
        cfg_index <= vrt_pkg::CFG_WATER_ID; cfg_wdata <= water[11:0]; @(negedge aclk);
        cfg_index <= vrt_pkg::CFG_X_OFFSET; cfg_wdata <= xo[11:0];    @(negedge aclk);
        cfg_index <= vrt_pkg::CFG_Z_OFFSET; cfg_wdata <= zo[11:0];    @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
        cur_x_off = xo;
        cur_z_off = zo;
    endtask

    function automatic int clamp_cell(int c);
        return (c < -2048) ? -2048 : (c > 2047) ? 2047 : c;
    endfunction

    function automatic int rand_dir();
        return ($urandom_range(99) < 15) ? 0 : $signed(16'($urandom));
    endfunction

    task automatic random_item;
        int pick, ox, oy, oz;
        logic [vrt_pkg::S_DATA_W-1:0] d;
        pick = $urandom_range(99);
        if (pick < 35) begin
            send_item(vrt_pkg::OP_WRITE, write_data($urandom_range(31) - cur_x_off,
                      $urandom_range(31), $urandom_range(31) - cur_z_off,
                      ($urandom_range(3) == 0) ? $urandom_range(1) : $urandom_range(255)));
        end else if (pick < 90) begin
            ox = clamp_cell($urandom_range(35) - 2 - cur_x_off) * 4096;
            oy = clamp_cell($urandom_range(35) - 2) * 4096;
            oz = clamp_cell($urandom_range(35) - 2 - cur_z_off) * 4096;
            if ($urandom_range(4) != 0) begin
                ox += $urandom_range(4095);
                oy += $urandom_range(4095);
                oz += $urandom_range(4095);
            end
            send_item(vrt_pkg::OP_RAY, ray_data(ox, oy, oz, rand_dir(), rand_dir(), rand_dir(),
                      ($urandom_range(9) == 0) ? $urandom_range(65535) : $urandom_range(12000)));
        end else begin
            d = vrt_pkg::S_DATA_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
            d[vrt_pkg::S_DATA_W-1:180] = '0;
            send_item(logic'($urandom_range(1)), d);
        end
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tuser   = 1'b0;
        s_tdata   = '0;
        cfg_we    = 1'b0;
        cfg_index = vrt_pkg::CFG_AIR_ID;
        cfg_wdata = '0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part under reset register values.
        send_item(vrt_pkg::OP_WRITE, write_data(5, 5, 5, 7));
        send_item(vrt_pkg::OP_WRITE, write_data(31, 31, 31, 255));
        send_item(vrt_pkg::OP_WRITE, write_data(0, 0, 0, 1));
        send_item(vrt_pkg::OP_WRITE, write_data(-2048, -2048, 2047, 0));
        send_item(vrt_pkg::OP_WRITE, write_data(2047, 0, -2048, 200));
        send_item(vrt_pkg::OP_WRITE, write_data(8, 5, 5, 3));
        send_item(vrt_pkg::OP_RAY, ray_data(22528, 22528, 2048, 0, 0, 16384, 8192));
        send_item(vrt_pkg::OP_RAY, ray_data(22528, 22528, 40960, 0, 0, -16384, 8192));
        send_item(vrt_pkg::OP_RAY, ray_data(20480, 20480, 0, 0, 0, 16384, 8192));
        send_item(vrt_pkg::OP_RAY, ray_data(2048, 22528, 22528, 16384, 0, 0, 65535));
        send_item(vrt_pkg::OP_RAY, ray_data(22528, 22528, 2048, 0, 0, 0, 8192));
        send_item(vrt_pkg::OP_RAY, ray_data(22528, 22528, 2048, 0, 0, 16384, 0));
        send_item(vrt_pkg::OP_RAY, ray_data(22528, 22528, 2048, 0, 0, 16384, 256));
        send_item(vrt_pkg::OP_RAY, ray_data(16384, 16384, 16384, 16384, 16384, 16384, 8192));
        send_item(vrt_pkg::OP_RAY, ray_data(4096, 4096, 4096, 16384, 16384, 16384, 16384));
        send_item(vrt_pkg::OP_RAY,
                  ray_data(126976, 126976, 126976, -32768, -32768, -32768, 65535));
        send_item(vrt_pkg::OP_RAY,
                  ray_data(-8388608, -8388608, -8388608, 32767, 32767, 32767, 65535));
        send_item(vrt_pkg::OP_RAY,
                  ray_data(8388607, 8388607, 8388607, -32768, 1, -1, 65535));
        send_item(vrt_pkg::OP_RAY, ray_data(-4096, 22528, 22528, 32767, 0, 0, 65535));
        send_item(vrt_pkg::OP_RAY, ray_data(20480, 20480, 20480, 32767, 1, 1, 65535));
        drain();

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                1: begin
                    set_regs(255, 0, -2048, 2047);
                end
                2: begin
                    set_regs(2, 9, -7, 5);
                end
                3: begin
                    set_regs(0, 1, 2047, -2048);
                end
                4: begin
                    set_regs(3, 0, -16, -16);
                end
                default: begin
                end
            endcase
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                if (phase == 2 && i == 30) hold_req = 1'b1;
                if (phase == 2 && i == 70) drain();
                calm = (phase == 4 && i < 60);
                random_item();
            end
            calm = 1'b0;
            drain();
        end

        repeat (50) @(negedge aclk);
        $display("Sent %0d items (%0d rays) over five register settings; %0d rays hit.",
                 items_sent, rays_sent, hit_count);
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d failures, %0d results outstanding.", fail_count, pending);
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

### sim.f
rtl/vrt_pkg.sv
rtl/voxel_ray_traversal.sv
sim/vrt_checker.sv
sim/tb.sv
